@@ src/rne_pkg.sv @@
// Shared types, constants and symbol table for the Roman numeral encoder.
package rne_pkg;

   localparam int ValueW   = 12;
   localparam int LetterW  = 7;
   localparam int WeightW  = 10;
   localparam int MaxValid = 3000;
   localparam int NumSyms  = 13;
   localparam int SymIdxW  = $clog2(NumSyms);
   localparam int QDepth   = 2;
   localparam int QPtrW    = (QDepth > 1) ? $clog2(QDepth) : 1;
   localparam int QCntW    = $clog2(QDepth + 1);

   localparam logic [LetterW-1:0] LetNone = 7'd0;
   localparam logic [LetterW-1:0] LetI    = 7'h49;
   localparam logic [LetterW-1:0] LetV    = 7'h56;
   localparam logic [LetterW-1:0] LetX    = 7'h58;
   localparam logic [LetterW-1:0] LetL    = 7'h4C;
   localparam logic [LetterW-1:0] LetC    = 7'h43;
   localparam logic [LetterW-1:0] LetD    = 7'h44;
   localparam logic [LetterW-1:0] LetM    = 7'h4D;

   typedef struct packed {
      logic [ValueW-1:0] value;
      logic              error;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

   function automatic logic [WeightW-1:0] sym_weight(input logic [SymIdxW-1:0] idx);
      logic [WeightW-1:0] w;
      case (idx)
         4'd0:    w = 10'd1000;
         4'd1:    w = 10'd900;
         4'd2:    w = 10'd500;
         4'd3:    w = 10'd400;
         4'd4:    w = 10'd100;
         4'd5:    w = 10'd90;
         4'd6:    w = 10'd50;
         4'd7:    w = 10'd40;
         4'd8:    w = 10'd10;
         4'd9:    w = 10'd9;
         4'd10:   w = 10'd5;
         4'd11:   w = 10'd4;
         default: w = 10'd1;
      endcase
      return w;
   endfunction

   function automatic logic [LetterW-1:0] sym_first(input logic [SymIdxW-1:0] idx);
      logic [LetterW-1:0] c;
      case (idx)
         4'd0:    c = LetM;
         4'd1:    c = LetC;
         4'd2:    c = LetD;
         4'd3:    c = LetC;
         4'd4:    c = LetC;
         4'd5:    c = LetX;
         4'd6:    c = LetL;
         4'd7:    c = LetX;
         4'd8:    c = LetX;
         4'd9:    c = LetI;
         4'd10:   c = LetV;
         4'd11:   c = LetI;
         default: c = LetI;
      endcase
      return c;
   endfunction

   // LetNone for single-letter symbols
   function automatic logic [LetterW-1:0] sym_second(input logic [SymIdxW-1:0] idx);
      logic [LetterW-1:0] c;
      case (idx)
         4'd1:    c = LetM;
         4'd3:    c = LetD;
         4'd5:    c = LetC;
         4'd7:    c = LetL;
         4'd9:    c = LetX;
         4'd11:   c = LetV;
         default: c = LetNone;
      endcase
      return c;
   endfunction

endpackage

@@ src/rne_front.sv @@
// Front end: accepts transactions, flags out-of-range values, queues them.
module rne_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [rne_pkg::ValueW-1:0] req_value,
   output logic                      busy,
   input  logic                      pop,
   output rne_pkg::head_type         head
);
   import rne_pkg::*;

   entry_type        mem_ff [QDepth];
   logic [QPtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCntW-1:0] count_ff, count_in;
   logic             push;
   logic             do_pop;
   entry_type        new_entry;

   assign busy   = (count_ff == QCntW'(QDepth));
   assign push   = start && !busy;
   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      new_entry.value = req_value;
      new_entry.error = (req_value == '0) || (req_value > ValueW'(MaxValid));
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= new_entry;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.entry = mem_ff[rd_ptr_ff];

endmodule

@@ src/rne_back.sv @@
// Back end: greedy symbol selection, one letter per cycle.
module rne_back (
   input  logic                        clock,
   input  logic                        reset,
   input  rne_pkg::head_type           head,
   output logic                        pop,
   output logic                        rsp_valid,
   output logic [rne_pkg::LetterW-1:0] rsp_letter,
   output logic                        rsp_last,
   output logic                        rsp_error
);
   import rne_pkg::*;

   logic               active_ff;
   logic               error_ff;
   logic               pend_ff;
   logic [LetterW-1:0] pend_letter_ff;
   logic [ValueW-1:0]  value_ff, value_in;
   logic [SymIdxW-1:0] sel;
   logic [LetterW-1:0] second;
   logic               last_now;

   always_comb begin
      sel = SymIdxW'(NumSyms - 1);
      for (int i = NumSyms - 1; i >= 0; i--) begin
         if (value_ff >= ValueW'(sym_weight(SymIdxW'(i)))) begin
            sel = SymIdxW'(i);
         end
      end
   end

   assign second   = sym_second(sel);
   assign value_in = value_ff - ValueW'(sym_weight(sel));

   always_comb begin
      rsp_letter = LetNone;
      last_now   = 1'b0;
      if (error_ff) begin
         last_now = 1'b1;
      end else if (pend_ff) begin
         rsp_letter = pend_letter_ff;
         last_now   = (value_ff == '0);
      end else begin
         rsp_letter = sym_first(sel);
         last_now   = (second == LetNone) && (value_in == '0);
      end
   end

   assign rsp_valid = active_ff;
   assign rsp_last  = active_ff && last_now;
   assign rsp_error = active_ff && error_ff;
   assign pop       = !active_ff || last_now;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pend_ff   <= 1'b0;
         error_ff  <= 1'b0;
      end else if (pop) begin
         active_ff      <= head.valid;
         pend_ff        <= 1'b0;
         error_ff       <= head.entry.error;
         value_ff       <= head.entry.value;
      end else if (pend_ff) begin
         pend_ff <= 1'b0;
      end else begin
         value_ff <= value_in;
         if (second != LetNone) begin
            pend_ff        <= 1'b1;
            pend_letter_ff <= second;
         end
      end
   end

endmodule

@@ src/roman_numeral_encoder_top.sv @@
// Roman numeral encoder: front-end queue plus letter-emitting back end.
// A taken start is queued, then loaded into an idle back end to emit its first letter.
// Each value yields 1 to 14 letters; an error yields a single empty result.
// Back end runs items back to back; busy rises while the 2-entry queue is full.
// Reset is synchronous and clears the queue and the back end; stored values are not reset.
module roman_numeral_encoder_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [rne_pkg::ValueW-1:0]  req_value,
   output logic                        rsp_valid,
   output logic [rne_pkg::LetterW-1:0] rsp_letter,
   output logic                        rsp_last,
   output logic                        rsp_error
);
   import rne_pkg::*;

   head_type head;
   logic     pop;

   rne_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_value (req_value),
      .busy      (busy),
      .pop       (pop),
      .head      (head)
   );

   rne_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_letter (rsp_letter),
      .rsp_last   (rsp_last),
      .rsp_error  (rsp_error)
   );

`ifndef ASSERT_OFF
   a_err_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_last && (rsp_letter == LetNone))
      else $error("error transaction not a single empty result");

   a_letter_ok : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_error |-> (rsp_letter == LetI) || (rsp_letter == LetV) ||
         (rsp_letter == LetX) || (rsp_letter == LetL) || (rsp_letter == LetC) ||
         (rsp_letter == LetD) || (rsp_letter == LetM))
      else $error("illegal letter emitted");

   a_reset_quiet : assert property (@(posedge clock)
      reset |=> !rsp_valid && !busy)
      else $error("activity right after reset");

   a_no_strobe_empty : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !busy |=> !(rsp_valid && $past(!start)) || $past(rsp_valid) ||
         $past(busy) || $past(start, 2) || $past(busy, 2))
      else $error("result without an accepted transaction");
`endif

endmodule
